@@ hw/rtl/rv64_decode_execute_unit_macros.svh @@
// Assertion macros shared by the decode/execute RTL
`ifndef RV64_DECODE_EXECUTE_UNIT_MACROS_SVH
`define RV64_DECODE_EXECUTE_UNIT_MACROS_SVH

// Implication checked every clock outside reset
`define RDE_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define RDE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

@@ hw/rtl/rde_pkg.sv @@
// ---------------------------------------------------------------------------
// rde_pkg
// Types and constants for the RV64IM subset decode/execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc;
        logic [63:0] rs1_value;
        logic [63:0] rs2_value;
    } rde_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_reg;
        logic [63:0] result;
        logic        load_from_memory;
        logic [2:0]  mem_read_size;
        logic [2:0]  mem_write_size;
        logic [63:0] mem_address;
        logic [63:0] store_data;
        logic [31:0] next_pc;
        logic        branch_taken;
        logic        environment_call;
        logic        illegal;
    } rde_out_t;

    // operation class chosen by the front end
    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
        OP_ADDW, OP_MUL, OP_MULH, OP_MULW, OP_DIV, OP_REM,
        OP_LUI, OP_UPPER_PC, OP_JAL, OP_JALR,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE,
        OP_LOAD, OP_STORE, OP_ECALL, OP_ILLEGAL
    } rde_op_t;

    // decoded item passed from front to back
    typedef struct packed {
        rde_op_t     op;
        logic [4:0]  rd;
        logic [2:0]  size;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] imm;
        logic [31:0] pc;
    } rde_dec_t;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OPIMMW = 7'h1b;
    localparam logic [6:0] OPC_OPW    = 7'h3b;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [31:0] LINK_STEP  = 32'd4;
    localparam int DIV_STEPS_PER_STAGE = 4;

endpackage

`default_nettype wire

@@ hw/rtl/rde_front.sv @@
// ---------------------------------------------------------------------------
// rde_front
// Decodes one instruction word into an operation class and operands.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rde_pkg::rde_in_t in_data,
    output logic                 dec_valid,
    input  wire logic            dec_ready,
    output rde_pkg::rde_dec_t    dec_data
);
    import rde_pkg::*;

    logic       valid_reg;
    rde_dec_t   data_reg;
    rde_dec_t   dec_next;
    logic [31:0] iw;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;

    assign iw  = in_data.instruction;
    assign opc = iw[6:0];
    assign f3  = iw[14:12];
    assign f7  = iw[31:25];
    assign f6  = iw[31:26];

    // classify and pick the immediate
    always_comb
    begin
        dec_next.rd   = iw[11:7];
        dec_next.size = 3'd0;
        dec_next.a    = in_data.rs1_value;
        dec_next.b    = in_data.rs2_value;
        dec_next.pc   = in_data.pc;
        dec_next.imm  = {{52{iw[31]}}, iw[31:20]};
        dec_next.op   = OP_ILLEGAL;
        case (opc)
            OPC_OP:
            begin
                if (f7 == 7'h00)
                begin
                    case (f3)
                        3'd0: dec_next.op = OP_ADD;
                        3'd1: dec_next.op = OP_SLL;
                        3'd2: dec_next.op = OP_SLT;
                        3'd4: dec_next.op = OP_XOR;
                        3'd5: dec_next.op = OP_SRL;
                        3'd6: dec_next.op = OP_OR;
                        3'd7: dec_next.op = OP_AND;
                        default: dec_next.op = OP_ILLEGAL;
                    endcase
                end
                else if (f7 == 7'h20)
                begin
                    if (f3 == 3'd0)      dec_next.op = OP_SUB;
                    else if (f3 == 3'd5) dec_next.op = OP_SRA;
                end
                else if (f7 == 7'h01)
                begin
                    case (f3)
                        3'd0: dec_next.op = OP_MUL;
                        3'd1: dec_next.op = OP_MULH;
                        3'd4: dec_next.op = OP_DIV;
                        3'd6: dec_next.op = OP_REM;
                        default: dec_next.op = OP_ILLEGAL;
                    endcase
                end
                // low 6 bits of rs2 form the shift amount
                if (f3 == 3'd1 || f3 == 3'd5)
                    dec_next.imm = {58'd0, in_data.rs2_value[5:0]};
            end
            OPC_OPIMM:
            begin
                dec_next.b = dec_next.imm;
                case (f3)
                    3'd0: dec_next.op = OP_ADD;
                    3'd2: dec_next.op = OP_SLT;
                    3'd4: dec_next.op = OP_XOR;
                    3'd6: dec_next.op = OP_OR;
                    3'd7: dec_next.op = OP_AND;
                    3'd1: if (f6 == 6'h00) dec_next.op = OP_SLL;
                    3'd5:
                    begin
                        if (f6 == 6'h00)      dec_next.op = OP_SRL;
                        else if (f6 == 6'h10) dec_next.op = OP_SRA;
                    end
                    default: dec_next.op = OP_ILLEGAL;
                endcase
                if (f3 == 3'd1 || f3 == 3'd5)
                    dec_next.imm = {58'd0, iw[25:20]};
            end
            OPC_OPIMMW:
            begin
                dec_next.b = dec_next.imm;
                if (f3 == 3'd0) dec_next.op = OP_ADDW;
            end
            OPC_OPW:
            begin
                if (f3 == 3'd0 && f7 == 7'h00)      dec_next.op = OP_ADDW;
                else if (f3 == 3'd0 && f7 == 7'h01) dec_next.op = OP_MULW;
            end
            OPC_LUI:
            begin
                dec_next.op  = OP_LUI;
                dec_next.imm = {{32{iw[31]}}, iw[31:12], 12'd0};
            end
            OPC_AUIPC:
            begin
                dec_next.op  = OP_UPPER_PC;
                dec_next.imm = {{32{iw[31]}}, iw[31:12], 12'd0};
            end
            OPC_JAL:
            begin
                dec_next.op  = OP_JAL;
                dec_next.imm = {{44{iw[31]}}, iw[19:12], iw[20], iw[30:21], 1'b0};
            end
            OPC_JALR:
            begin
                if (f3 == 3'd0) dec_next.op = OP_JALR;
            end
            OPC_BRANCH:
            begin
                dec_next.imm = {{52{iw[31]}}, iw[7], iw[30:25], iw[11:8], 1'b0};
                case (f3)
                    3'd0: dec_next.op = OP_BEQ;
                    3'd1: dec_next.op = OP_BNE;
                    3'd4: dec_next.op = OP_BLT;
                    3'd5: dec_next.op = OP_BGE;
                    default: dec_next.op = OP_ILLEGAL;
                endcase
            end
            OPC_LOAD:
            begin
                dec_next.size = {1'b0, f3[1:0]} + 3'd1;
                if (!f3[2]) dec_next.op = OP_LOAD;
            end
            OPC_STORE:
            begin
                dec_next.size = {1'b0, f3[1:0]} + 3'd1;
                dec_next.imm  = {{52{iw[31]}}, iw[31:25], iw[11:7]};
                if (!f3[2]) dec_next.op = OP_STORE;
            end
            OPC_SYSTEM:
            begin
                if (iw == ECALL_WORD) dec_next.op = OP_ECALL;
            end
            default: dec_next.op = OP_ILLEGAL;
        endcase
    end

    // output register; refills whenever the downstream takes or it is empty
    assign in_ready  = !valid_reg || dec_ready;
    assign dec_valid = valid_reg;
    assign dec_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= dec_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rde_queue.sv @@
// ---------------------------------------------------------------------------
// rde_queue
// Two-entry queue that decouples the decode front from the execute back.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire rde_pkg::rde_dec_t wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output rde_pkg::rde_dec_t     rd_data
);
    import rde_pkg::*;

    `include "rv64_decode_execute_unit_macros.svh"

    rde_dec_t   mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

    `RDE_ASSERT_IMPL(a_q_count_max, clk, rst_n, 1'b1, count_reg <= 2'd2, "queue overfilled")
    `RDE_ASSERT_IMPL(a_q_ptr_full, clk, rst_n, count_reg == 2'd2, wptr_reg == rptr_reg,
                     "queue pointers disagree when full")
    `RDE_ASSERT_NEXT(a_q_push_only, clk, rst_n, push && !pop && count_reg == 2'd0,
                     count_reg == 2'd1, "queue count missed a transfer")

endmodule

`default_nettype wire

@@ hw/rtl/rde_divider.sv @@
// ---------------------------------------------------------------------------
// rde_divider
// Pipelined restoring divider on 64-bit magnitudes, a few quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_divider
#(
    parameter int StepsPerStage = 4
)
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic      [63:0] quotient,
    output logic      [63:0] remainder
);
    localparam int Stages = 64 / StepsPerStage;

    // stage s output registers
    logic [63:0] q_reg [Stages];
    logic [63:0] r_reg [Stages];
    logic [63:0] d_reg [Stages];

    // each stage shifts in StepsPerStage dividend bits
    for (genvar s = 0; s < Stages; s++)
    begin : g_stage
        logic [63:0] q_in;
        logic [63:0] r_in;
        logic [63:0] d_in;
        logic [63:0] q_next;
        logic [63:0] r_next;
        if (s == 0)
        begin : g_first
            assign q_in = dividend;
            assign r_in = 64'd0;
            assign d_in = divisor;
        end
        else
        begin : g_rest
            assign q_in = q_reg[s-1];
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
        end
        always_comb
        begin
            logic [64:0] trial;
            q_next = q_in;
            r_next = r_in;
            for (int k = 0; k < StepsPerStage; k++)
            begin
                trial  = {r_next, q_next[63]};
                q_next = {q_next[62:0], 1'b0};
                if (trial >= {1'b0, d_in})
                begin
                    trial     = trial - {1'b0, d_in};
                    q_next[0] = 1'b1;
                end
                r_next = trial[63:0];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s] <= q_next;
                r_reg[s] <= r_next;
                d_reg[s] <= d_in;
            end
        end
    end

    assign quotient  = q_reg[Stages-1];
    assign remainder = r_reg[Stages-1];

endmodule

`default_nettype wire

@@ hw/rtl/rde_back.sv @@
// ---------------------------------------------------------------------------
// rde_back
// Execute pipeline: ALU, multiplier and divider results, one entry per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              dec_valid,
    output logic                   dec_ready,
    input  wire rde_pkg::rde_dec_t dec_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rde_pkg::rde_out_t      out_data
);
    import rde_pkg::*;

    `include "rv64_decode_execute_unit_macros.svh"

    localparam int DivLat = 64 / DIV_STEPS_PER_STAGE;
    // stage 0 executes, stage 1 sums the partial products, stage 2 places the
    // product; the pipe is as deep as the divider, and the last stage fixes
    // signs and forms the result
    localparam int Depth = DivLat;

    logic     en;
    logic     v_reg [Depth];
    rde_out_t o_reg [Depth];
    rde_op_t  op_reg [Depth];
    logic     dneg_reg [Depth];
    logic     special_reg [Depth];
    logic [63:0] sv_reg [Depth];
    logic [63:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [63:0] mul_lo_reg, mul_hi_reg;
    logic [63:0] a1_reg, b1_reg;
    logic [63:0] mid, mul_lo, mul_hi, a1, b1;
    rde_out_t    o2;

    // stall the whole pipe only when its last stage holds an untaken result
    assign en        = !v_reg[Depth-1] || out_ready;
    assign dec_ready = en;
    assign out_valid = v_reg[Depth-1];

    // stage 0: ALU, branches, addresses, multiplier/divider operand prep
    rde_out_t o0;
    logic     dneg0;
    logic     special0;
    logic [63:0] sv0;
    logic [63:0] ua, ub;
    logic [63:0] a, b, imm;
    logic [63:0] sum_ai;
    logic        lt;
    logic [31:0] seq;

    assign a   = dec_data.a;
    assign b   = dec_data.b;
    assign imm = dec_data.imm;
    assign sum_ai = a + imm;
    assign lt  = $signed(a) < $signed(b);
    assign seq = dec_data.pc + LINK_STEP;

    always_comb
    begin
        logic [63:0] add_w;
        o0 = '0;
        o0.next_pc      = seq;
        o0.write_enable = 1'b1;
        o0.dest_reg     = dec_data.rd;
        dneg0 = 1'b0;
        special0 = 1'b0;
        sv0 = 64'd0;
        ua = a[63] ? (64'd0 - a) : a;
        ub = b[63] ? (64'd0 - b) : b;
        add_w = a + b;
        case (dec_data.op)
            OP_ADD:   o0.result = a + b;
            OP_SUB:   o0.result = a - b;
            OP_SLL:   o0.result = a << imm[5:0];
            OP_SLT:   o0.result = {63'd0, lt};
            OP_XOR:   o0.result = a ^ b;
            OP_SRL:   o0.result = a >> imm[5:0];
            OP_SRA:   o0.result = $unsigned($signed(a) >>> imm[5:0]);
            OP_OR:    o0.result = a | b;
            OP_AND:   o0.result = a & b;
            OP_ADDW:  o0.result = {{32{add_w[31]}}, add_w[31:0]};
            OP_MUL, OP_MULH, OP_MULW: o0.result = 64'd0;
            OP_DIV, OP_REM:
            begin
                // divide by zero and overflow skip the divider result
                if (b == 64'd0)
                begin
                    special0 = 1'b1;
                    sv0 = (dec_data.op == OP_REM) ? a : '1;
                end
                else if (a == {1'b1, 63'd0} && b == '1)
                begin
                    special0 = 1'b1;
                    sv0 = (dec_data.op == OP_REM) ? 64'd0 : a;
                end
                dneg0 = (dec_data.op == OP_REM) ? a[63] : (a[63] ^ b[63]);
            end
            OP_LUI:   o0.result = imm;
            OP_UPPER_PC: o0.result = {32'd0, dec_data.pc} + imm;
            OP_JAL:
            begin
                o0.result = {32'd0, seq};
                o0.branch_taken = 1'b1;
                o0.next_pc = dec_data.pc + imm[31:0];
            end
            OP_JALR:
            begin
                o0.result = {32'd0, seq};
                o0.branch_taken = 1'b1;
                o0.next_pc = {sum_ai[31:1], 1'b0};
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE:
            begin
                o0.write_enable = 1'b0;
                o0.dest_reg = 5'd0;
                case (dec_data.op)
                    OP_BEQ:  o0.branch_taken = (a == b);
                    OP_BNE:  o0.branch_taken = (a != b);
                    OP_BLT:  o0.branch_taken = lt;
                    default: o0.branch_taken = !lt;
                endcase
                if (o0.branch_taken)
                    o0.next_pc = dec_data.pc + imm[31:0];
            end
            OP_LOAD:
            begin
                o0.load_from_memory = 1'b1;
                o0.mem_read_size = dec_data.size;
                o0.mem_address = sum_ai;
            end
            OP_STORE:
            begin
                o0.write_enable = 1'b0;
                o0.dest_reg = 5'd0;
                o0.mem_write_size = dec_data.size;
                o0.mem_address = sum_ai;
                o0.store_data = b;
            end
            OP_ECALL:
            begin
                o0.write_enable = 1'b0;
                o0.dest_reg = 5'd0;
                o0.environment_call = 1'b1;
            end
            default:
            begin
                o0.write_enable = 1'b0;
                o0.dest_reg = 5'd0;
                o0.illegal = 1'b1;
            end
        endcase
    end

    // unsigned divider, fed each cycle that the pipe advances; latency lines up with the pipe
    logic [63:0] div_q, div_r;
    rde_divider #(.StepsPerStage(DIV_STEPS_PER_STAGE)) u_div
    (
        .clk       (clk),
        .en        (en),
        .dividend  (ua),
        .divisor   (ub),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // control and sideband pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= dec_valid;
            for (int i = 1; i < Depth; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0]       <= o0;
            op_reg[0]      <= dec_data.op;
            dneg_reg[0]    <= dneg0;
            special_reg[0] <= special0;
            sv_reg[0]      <= sv0;
            for (int i = 1; i < Depth; i++)
            begin
                o_reg[i]       <= (i == 2) ? o2 : o_reg[i-1];
                op_reg[i]      <= op_reg[i-1];
                dneg_reg[i]    <= dneg_reg[i-1];
                special_reg[i] <= special_reg[i-1];
                sv_reg[i]      <= sv_reg[i-1];
            end
            // multiplier: 32x32 partials, then sums
            pp_ll_reg <= a[31:0] * b[31:0];
            pp_lh_reg <= a[31:0] * b[63:32];
            pp_hl_reg <= a[63:32] * b[31:0];
            pp_hh_reg <= a[63:32] * b[63:32];
            mul_lo_reg <= mul_lo;
            mul_hi_reg <= mul_hi;
        end
    end

    // stage 1: combine partial products (signed correction for mulh)
    assign a1  = a1_reg;
    assign b1  = b1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a;
            b1_reg <= b;
        end
    end
    always_comb
    begin
        mid = {32'd0, pp_ll_reg[63:32]} + {32'd0, pp_lh_reg[31:0]} +
              {32'd0, pp_hl_reg[31:0]};
        mul_lo = {mid[31:0], pp_ll_reg[31:0]};
        mul_hi = pp_hh_reg + {32'd0, pp_lh_reg[63:32]} + {32'd0, pp_hl_reg[63:32]} +
                 {32'd0, mid[63:32]} - (a1[63] ? b1 : 64'd0) - (b1[63] ? a1 : 64'd0);
    end

    // stage 2: place the product into the result
    always_comb
    begin
        o2 = o_reg[1];
        case (op_reg[1])
            OP_MUL:  o2.result = mul_lo_reg;
            OP_MULH: o2.result = mul_hi_reg;
            OP_MULW: o2.result = {{32{mul_lo_reg[31]}}, mul_lo_reg[31:0]};
            default: o2.result = o_reg[1].result;
        endcase
    end

    // final: divider result with sign fix
    always_comb
    begin
        logic [63:0] mag;
        out_data = o_reg[Depth-1];
        mag = (op_reg[Depth-1] == OP_REM) ? div_r : div_q;
        if (op_reg[Depth-1] == OP_DIV || op_reg[Depth-1] == OP_REM)
        begin
            if (special_reg[Depth-1])
                out_data.result = sv_reg[Depth-1];
            else
                out_data.result = dneg_reg[Depth-1] ? (64'd0 - mag) : mag;
        end
    end

    `RDE_ASSERT_IMPL(a_b_illegal_quiet, clk, rst_n, out_valid && out_data.illegal,
                     !out_data.write_enable && !out_data.branch_taken,
                     "illegal result carries side effects")
    `RDE_ASSERT_IMPL(a_b_mem_excl, clk, rst_n, out_valid,
                     out_data.mem_read_size == 3'd0 || out_data.mem_write_size == 3'd0,
                     "load and store at once")
    `RDE_ASSERT_NEXT(a_b_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                     "result dropped while stalled")

endmodule

`default_nettype wire

@@ hw/rtl/rv64_decode_execute_unit.sv @@
// ---------------------------------------------------------------------------
// rv64_decode_execute_unit
// RV64IM subset decode and execute: decode front, queue, execute back.
// ---------------------------------------------------------------------------
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid/in_ready   | rde_in_t  (instruction, pc, rs1, rs2)
// out      | output    | out_valid/out_ready | rde_out_t (writeback, memory, next pc)
//
// One instruction per cycle sustained while the output is taken. The input transfer
// loads the decode register, the queue registers it, then come 16 execute stages,
// a depth set by the 16-stage divider (4 bits a stage).
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the execute pipe; the queue lets decode run on.
// ---------------------------------------------------------------------------
`default_nettype none

module rv64_decode_execute_unit
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rde_pkg::rde_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rde_pkg::rde_out_t      out_data
);
    import rde_pkg::*;

    logic     f_valid, f_ready, q_valid, q_ready;
    rde_dec_t f_data, q_data;

    rde_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .dec_valid (f_valid),
        .dec_ready (f_ready),
        .dec_data  (f_data)
    );

    rde_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    rde_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (q_valid),
        .dec_ready (q_ready),
        .dec_data  (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ test/tb_rv64_decode_execute_unit.sv @@
// ---------------------------------------------------------------------------
// tb_rv64_decode_execute_unit
// Drives RV64IM subset instructions through the decode/execute unit and
// compares every writeback, memory and next-pc result against a behavioral
// model kept in this file. Both handshake sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rv64_decode_execute_unit;
    import rde_pkg::*;

    // funct3 / funct7 codes used when building words
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_XOR = 3'd4;
    localparam logic [2:0] F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_MULH = 3'd1, F3_DIV = 3'd4, F3_REM = 3'd6;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20, F7_MULDIV = 7'h01;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    rde_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    rde_out_t out_data;

    rde_out_t expected_results[$];
    int       error_count;
    longint unsigned cycle_count;
    bit       calm;          // no idling on either side while set

    rv64_decode_execute_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_rv64_decode_execute_unit failed");
            $finish;
        end
    end

    function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        v = v & ((bits >= 64) ? ~64'd0 : ((64'd1 << bits) - 1));
        return (v ^ m) - m;
    endfunction

    function automatic logic [63:0] signed_div(input logic [63:0] a, input logic [63:0] b,
                                               input bit want_rem);
        if (b == 0) return want_rem ? a : ~64'd0;
        if (a == MIN64 && b == ~64'd0) return want_rem ? 64'd0 : a;
        if (want_rem) return $signed(a) % $signed(b);
        return $signed(a) / $signed(b);
    endfunction

    // expected decode/execute outcome of one instruction
    function automatic rde_out_t execute_instruction(input rde_in_t x);
        rde_out_t    r;
        logic [31:0] w;
        logic [6:0]  opc, f7;
        logic [2:0]  f3;
        logic [5:0]  f6, shamt;
        logic [63:0] a, b, immi, imms, immb, immj, immu;
        logic [127:0] prod;
        logic [31:0] seq;
        bit ill, taken;
        w = x.instruction; a = x.rs1_value; b = x.rs2_value;
        opc = w[6:0]; f3 = w[14:12]; f7 = w[31:25]; f6 = w[31:26]; shamt = w[25:20];
        immi = sx(w[31:20], 12);
        imms = sx({w[31:25], w[11:7]}, 12);
        immb = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        immj = sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        immu = sx({w[31:12], 12'd0}, 32);
        seq = x.pc + LINK_STEP;
        r = '0;
        r.next_pc = seq;
        ill = 0; taken = 0;
        case (opc)
            OPC_OP:
            begin
                r.write_enable = 1;
                if (f7 == F7_BASE)
                    case (f3)
                        F3_ADD: r.result = a + b;
                        F3_SLL: r.result = a << b[5:0];
                        F3_SLT: r.result = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        F3_XOR: r.result = a ^ b;
                        F3_SRL: r.result = a >> b[5:0];
                        F3_OR:  r.result = a | b;
                        F3_AND: r.result = a & b;
                        default: ill = 1;
                    endcase
                else if (f7 == F7_ALT && f3 == F3_ADD) r.result = a - b;
                else if (f7 == F7_ALT && f3 == F3_SRL) r.result = $signed(a) >>> b[5:0];
                else if (f7 == F7_MULDIV)
                    case (f3)
                        F3_ADD:  r.result = a * b;
                        F3_MULH:
                        begin
                            prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                            r.result = prod[127:64];
                        end
                        F3_DIV:  r.result = signed_div(a, b, 0);
                        F3_REM:  r.result = signed_div(a, b, 1);
                        default: ill = 1;
                    endcase
                else ill = 1;
            end
            OPC_OPIMM:
            begin
                r.write_enable = 1;
                case (f3)
                    F3_ADD: r.result = a + immi;
                    F3_SLT: r.result = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
                    F3_XOR: r.result = a ^ immi;
                    F3_OR:  r.result = a | immi;
                    F3_AND: r.result = a & immi;
                    F3_SLL: if (f6 == 0) r.result = a << shamt; else ill = 1;
                    F3_SRL:
                        if (f6 == 0) r.result = a >> shamt;
                        else if (f6 == 6'h10) r.result = $signed(a) >>> shamt;
                        else ill = 1;
                    default: ill = 1;
                endcase
            end
            OPC_OPIMMW:
            begin
                r.write_enable = 1;
                if (f3 == F3_ADD) r.result = sx(a + immi, 32); else ill = 1;
            end
            OPC_OPW:
            begin
                r.write_enable = 1;
                if (f3 == F3_ADD && f7 == F7_BASE) r.result = sx(a + b, 32);
                else if (f3 == F3_ADD && f7 == F7_MULDIV) r.result = sx(a * b, 32);
                else ill = 1;
            end
            OPC_LUI:   begin r.write_enable = 1; r.result = immu; end
            OPC_AUIPC: begin r.write_enable = 1; r.result = {32'd0, x.pc} + immu; end
            OPC_JAL:
            begin
                r.write_enable = 1; r.result = {32'd0, seq}; taken = 1;
                r.next_pc = x.pc + immj[31:0];
            end
            OPC_JALR:
                if (f3 == 0)
                begin
                    r.write_enable = 1; r.result = {32'd0, seq}; taken = 1;
                    r.next_pc = (a[31:0] + immi[31:0]) & ~32'd1;
                end
                else ill = 1;
            OPC_BRANCH:
            begin
                case (f3)
                    F3_BEQ: taken = (a == b);
                    F3_BNE: taken = (a != b);
                    F3_BLT: taken = ($signed(a) < $signed(b));
                    F3_BGE: taken = !($signed(a) < $signed(b));
                    default: ill = 1;
                endcase
                if (taken) r.next_pc = x.pc + immb[31:0];
            end
            OPC_LOAD:
                if (f3 <= 3)
                begin
                    r.write_enable = 1; r.load_from_memory = 1;
                    r.mem_read_size = f3 + 3'd1; r.mem_address = a + immi;
                end
                else ill = 1;
            OPC_STORE:
                if (f3 <= 3)
                begin
                    r.mem_write_size = f3 + 3'd1; r.mem_address = a + imms; r.store_data = b;
                end
                else ill = 1;
            OPC_SYSTEM:
                if (w == ECALL_WORD) r.environment_call = 1; else ill = 1;
            default: ill = 1;
        endcase
        r.branch_taken = taken;
        if (ill)
        begin
            r = '0;
            r.next_pc = seq;
            r.illegal = 1;
        end
        if (!r.write_enable) r.dest_reg = 0; else r.dest_reg = w[11:7];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return ~64'd0;
            2: return MIN64;
            3: return ~MIN64;
            4: return {60'd0, 4'($urandom)};
            5: return {{32{1'b1}}, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // send one instruction; valid stays up after the transfer unless an idle
    // cycle follows, checks happen in the output process
    task automatic send_instruction(input logic [31:0] w, input logic [31:0] pc,
                                    input logic [63:0] a, input logic [63:0] b);
        rde_in_t x;
        x.instruction = w; x.pc = pc; x.rs1_value = a; x.rs2_value = b;
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        expected_results.push_back(execute_instruction(x));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(input logic [31:0] w);
        send_instruction(w, $urandom, rand64(), rand64());
    endtask

    function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [2:0] f3,
                                           input logic [6:0] opc);
        return {f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), opc};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer, actual %h", $time, out_data);
            end
            else
            begin
                rde_out_t e;
                e = expected_results.pop_front();
                if (e !== out_data)
                begin
                    error_count++;
                    $display("%0t: mismatch expected %p", $time, e);
                    $display("%0t:          actual   %p", $time, out_data);
                end
            end
        end
    end

    // drop valid, then wait for every pending result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // directed: extremes, many of the operations and the special cases
    task automatic test_directed();
        send_instruction(ECALL_WORD, 32'hFFFF_FFFC, 64'd1, 64'd2);          // ecall, pc wrap
        send_instruction(32'h0010_0073, 32'd0, 64'd0, 64'd0);              // not ecall
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP}, 0, MIN64, ~64'd0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OPC_OP}, 0, MIN64, ~64'd0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP}, 0, 64'd7, 64'd0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OPC_OP}, 0, 64'd7, 64'd0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd3, OPC_OP}, 0, MIN64, MIN64);
        send_instruction({F7_BASE, 5'd2, 5'd1, F3_SLL, 5'd31, OPC_OP}, 0, ~64'd0, 64'hFF);
        send_instruction({F7_ALT, 5'd2, 5'd1, F3_SRL, 5'd31, OPC_OP}, 0, MIN64, 64'h7F);
        send_instruction({6'h10, 6'd63, 5'd1, F3_SRL, 5'd4, OPC_OPIMM}, 0, MIN64, 0);
        send_instruction({6'h01, 6'd3, 5'd1, F3_SLL, 5'd4, OPC_OPIMM}, 0, 64'd1, 0);
        send_instruction({12'hFFF, 5'd1, F3_ADD, 5'd5, OPC_OPIMMW}, 0, 64'h8000_0000, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd6, OPC_OPW}, 0, ~64'd0, 64'd3);
        send_instruction({20'hFFFFF, 5'd7, OPC_LUI}, 0, 0, 0);
        send_instruction({20'h80000, 5'd7, OPC_AUIPC}, 32'hFFFF_FFFF, 0, 0);
        send_instruction({20'hFFFFF, 5'd1, OPC_JAL}, 32'hFFFF_FFFC, 0, 0);
        send_instruction({12'h7FF, 5'd1, 3'd0, 5'd1, OPC_JALR}, 0, ~64'd0, 0);
        send_instruction({7'h7F, 5'd2, 5'd1, F3_BGE, 5'h1F, OPC_BRANCH}, 8, MIN64, MIN64);
        send_instruction({7'h00, 5'd2, 5'd1, F3_BLT, 5'h02, OPC_BRANCH}, 8, MIN64, 64'd0);
        send_instruction({12'h800, 5'd1, 3'd3, 5'd8, OPC_LOAD}, 0, 64'd0, 0);
        send_instruction({12'h000, 5'd1, 3'd4, 5'd8, OPC_LOAD}, 0, 64'd0, 0);
        send_instruction({7'h7F, 5'd2, 5'd1, 3'd3, 5'h1F, OPC_STORE}, 0, 64'd0, ~64'd0);
        send_instruction(32'hFFFF_FFFF, 32'hFFFF_FFFF, ~64'd0, ~64'd0);
        send_instruction(32'h0000_0000, 32'h0, 64'd0, 64'd0);
    endtask

    // random: mostly well-formed words, the rest noise
    task automatic test_random(input int count);
        logic [31:0] w;
        logic [2:0]  f3;
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 3 && i < count / 3 + 150);
            f3 = 3'($urandom);
            case ($urandom_range(0, 13))
                0: w = r_word(F7_BASE, f3, OPC_OP);
                1: w = r_word(($urandom & 1) ? F7_ALT : F7_MULDIV, f3, OPC_OP);
                2: w = r_word({$urandom_range(0, 1) ? 6'h10 : 6'h00, 1'($urandom)},
                              f3, OPC_OPIMM);
                3: w = r_word(7'($urandom), f3, OPC_OPIMM);
                4: w = r_word(7'($urandom), ($urandom & 1) ? 3'd0 : f3, OPC_OPIMMW);
                5: w = r_word(($urandom & 1) ? F7_BASE : F7_MULDIV,
                              ($urandom & 1) ? 3'd0 : f3, OPC_OPW);
                6: w = r_word(7'($urandom), f3, ($urandom & 1) ? OPC_LUI : OPC_AUIPC);
                7: w = r_word(7'($urandom), f3, ($urandom & 1) ? OPC_JAL : OPC_JALR);
                8: w = r_word(7'($urandom), f3, OPC_BRANCH);
                9: w = r_word(7'($urandom), f3, OPC_LOAD);
                10: w = r_word(7'($urandom), f3, OPC_STORE);
                11: w = ($urandom & 1) ? ECALL_WORD : r_word(7'($urandom), f3, OPC_SYSTEM);
                default: w = $urandom;
            endcase
            if (w[6:0] == OPC_BRANCH && ($urandom & 1))
                send_instruction(w, $urandom, 64'd5, ($urandom & 1) ? 64'd5 : 64'd6);
            else
                send_random(w);
            if (i == count / 2)
                wait_drained();
        end
        calm = 0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        error_count = 0;
        cycle_count = 0;
        calm        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1300);
        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_rv64_decode_execute_unit passed");
        else
            $display("tb_rv64_decode_execute_unit failed");
        $finish;
    end

endmodule
